[rtl/core/sde_pkg.sv]
// shared types, constants and configuration codes of the scan detector
package sde_pkg;

    localparam int TRACKER_ENTRIES = 64;
    localparam int IDX_W = (TRACKER_ENTRIES > 1) ? $clog2(TRACKER_ENTRIES) : 1;

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 8;
    localparam int STRK_W  = 2;
    localparam int WIN_W   = 16;
    localparam int LEN_W   = 24;
    localparam int UNTIL_W = TIME_W + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CNT_W-1:0]  CNT_MAX    = '1;
    localparam logic [STRK_W-1:0] STRIKE_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SCAN_WINDOW = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_BLK   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SECOND_BLK  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_THIRD_BLK   = 3'd4;

    // strike codes
    localparam logic [STRK_W-1:0] STRIKE_ONE = 2'd1;
    localparam logic [STRK_W-1:0] STRIKE_TWO = 2'd2;

    // request types
    localparam logic REQ_CHECK   = 1'b0;
    localparam logic REQ_ATTEMPT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [KEY_W-1:0]  addr_key;
        logic [TIME_W-1:0] now_sec;
    } req_word_t;

    typedef struct packed {
        logic pass;
        logic tracked;
    } rsp_word_t;

    typedef struct packed {
        logic [WIN_W-1:0] scan_window_sec;
        logic [CNT_W-1:0] attempt_threshold;
        logic [LEN_W-1:0] first_block_sec;
        logic [LEN_W-1:0] second_block_sec;
        logic [LEN_W-1:0] third_block_sec;
    } cfg_t;

    // one tracker record as held in the tracker ram
    typedef struct packed {
        logic [UNTIL_W-1:0] ban_until;
        logic               is_banned;
        logic [STRK_W-1:0]  strike_count;
        logic [TIME_W-1:0]  window_start;
        logic [CNT_W-1:0]   attempt_count;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic             hit;
        logic             free;
        logic [IDX_W-1:0] idx;
    } lookup_t;

    typedef struct packed {
        logic we;
        logic set_valid;
        logic pass;
        logic tracked;
        rec_t rec;
    } upd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SELECT,
        ST_UPDATE
    } state_t;

endpackage

[rtl/core/sde_cam.sv]
// key store with valid bits, parallel match and first-hit / first-free encode
module sde_cam
    import sde_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             match_en,
    input  logic [KEY_W-1:0] key,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [KEY_W-1:0] wr_key,
    output lookup_t          lookup
);

    logic [TRACKER_ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]           key_reg [TRACKER_ENTRIES];
    logic [TRACKER_ENTRIES-1:0] hit_vec_reg;
    logic [TRACKER_ENTRIES-1:0] hit_vec_next;
    logic [TRACKER_ENTRIES-1:0] free_vec_reg;
    logic [IDX_W-1:0]           hit_idx;
    logic [IDX_W-1:0]           free_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg[wr_idx] <= wr_key;
        end
    end

    // compare against every entry
    always_comb
    begin
        for (int i = 0; i < TRACKER_ENTRIES; i++)
        begin
            hit_vec_next[i] = valid_reg[i] && (key_reg[i] == key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_en)
        begin
            hit_vec_reg  <= hit_vec_next;
            free_vec_reg <= ~valid_reg;
        end
    end

    // lowest set bit wins
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TRACKER_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit_vec_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (free_vec_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        lookup.hit  = |hit_vec_reg;
        lookup.free = |free_vec_reg;
        lookup.idx  = lookup.hit ? hit_idx : free_idx;
    end

endmodule

[rtl/core/sde_ram.sv]
// tracker record ram, one write and one registered read port
module sde_ram
    import sde_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  rec_t             wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output rec_t             rdata
);

    rec_t mem [TRACKER_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/core/sde_update.sv]
// tracker record update and verdict for one request
module sde_update
    import sde_pkg::*;
(
    input  req_word_t req,
    input  lookup_t   lookup,
    input  rec_t      rec,
    input  cfg_t      cfg,
    output upd_t      upd
);

    logic [TIME_W-1:0]  elapsed;
    logic [CNT_W-1:0]   cnt_inc;
    logic [STRK_W-1:0]  strike_inc;
    logic [LEN_W-1:0]   ban_len;
    logic [UNTIL_W-1:0] now_ext;

    always_comb
    begin
        now_ext    = {1'b0, req.now_sec};
        elapsed    = req.now_sec - rec.window_start;
        cnt_inc    = (rec.attempt_count != CNT_MAX) ? rec.attempt_count + 1'b1
                                                    : rec.attempt_count;
        strike_inc = (rec.strike_count != STRIKE_MAX) ? rec.strike_count + 1'b1
                                                      : rec.strike_count;
        case (strike_inc)
            STRIKE_ONE: ban_len = cfg.first_block_sec;
            STRIKE_TWO: ban_len = cfg.second_block_sec;
            default:    ban_len = cfg.third_block_sec;
        endcase

        upd.we        = 1'b0;
        upd.set_valid = 1'b0;
        upd.pass      = 1'b1;
        upd.tracked   = 1'b0;
        upd.rec       = rec;

        if (req.req_type == REQ_CHECK)
        begin
            if (lookup.hit)
            begin
                upd.tracked = 1'b1;
                if (rec.is_banned)
                begin
                    if (rec.ban_until > now_ext)
                    begin
                        upd.pass = 1'b0;
                    end
                    else
                    begin
                        // ban ran out: lift it and forget the history
                        upd.we                = 1'b1;
                        upd.rec.is_banned     = 1'b0;
                        upd.rec.attempt_count = '0;
                        upd.rec.strike_count  = '0;
                    end
                end
            end
        end
        else if (!lookup.hit)
        begin
            if (lookup.free)
            begin
                upd.we                = 1'b1;
                upd.set_valid         = 1'b1;
                upd.tracked           = 1'b1;
                upd.rec.attempt_count = CNT_W'(1);
                upd.rec.window_start  = req.now_sec;
                upd.rec.strike_count  = '0;
                upd.rec.is_banned     = 1'b0;
            end
        end
        else
        begin
            upd.we      = 1'b1;
            upd.tracked = 1'b1;
            if (elapsed > {{(TIME_W-WIN_W){1'b0}}, cfg.scan_window_sec})
            begin
                upd.rec.attempt_count = CNT_W'(1);
                upd.rec.window_start  = req.now_sec;
            end
            else if (cnt_inc > cfg.attempt_threshold)
            begin
                upd.rec.strike_count  = strike_inc;
                upd.rec.ban_until     = now_ext + {{(UNTIL_W-LEN_W){1'b0}}, ban_len};
                upd.rec.is_banned     = 1'b1;
                upd.rec.attempt_count = '0;
                upd.pass              = 1'b0;
            end
            else
            begin
                upd.rec.attempt_count = cnt_inc;
            end
        end
    end

endmodule

[rtl/core/scan_detect_escalating_block.sv]
// top level of the address scan detector with escalating ban
// result word registered when the update step commits; a stalled result holds the update step
// one request in flight: the next is taken only once the match, encode and
//   read-modify-write steps on the single tracker ram are done
// reset: config registers return to their defaults and all tracker valid bits
//   clear at once; no ram clearing pass, requests are taken right after reset
module scan_detect_escalating_block
    import sde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request channel
    input  logic                  req_valid,
    output logic                  req_stall,
    input  req_word_t             req_data,
    // result channel
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_word_t             rsp_data,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t    state_reg;
    state_t    state_next;
    cfg_t      cfg_reg;
    req_word_t req_reg;
    lookup_t   lookup;
    lookup_t   lk_reg;
    rec_t      rd_rec;
    upd_t      upd;
    logic      rsp_valid_reg;
    logic      rsp_valid_next;
    rsp_word_t rsp_data_reg;

    // control decoded from the state
    logic      req_take;
    logic      match_en;
    logic      ram_re;
    logic      slot_free;
    logic      commit;
    logic      ram_we;
    logic      cam_we;

    // configuration: always ready, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_window_sec   <= WIN_W'(60);
            cfg_reg.attempt_threshold <= CNT_W'(10);
            cfg_reg.first_block_sec   <= LEN_W'(300);
            cfg_reg.second_block_sec  <= LEN_W'(3600);
            cfg_reg.third_block_sec   <= LEN_W'(86400);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_SCAN_WINDOW: cfg_reg.scan_window_sec   <= cfg_data[WIN_W-1:0];
                CFG_THRESHOLD:   cfg_reg.attempt_threshold <= cfg_data[CNT_W-1:0];
                CFG_FIRST_BLK:   cfg_reg.first_block_sec   <= cfg_data;
                CFG_SECOND_BLK:  cfg_reg.second_block_sec  <= cfg_data;
                CFG_THIRD_BLK:   cfg_reg.third_block_sec   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // the result register is free when empty or being drained this cycle
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    // sequencer: idle -> match -> select (ram read) -> update (write back)
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:  state_next = ST_SELECT;
            ST_SELECT: state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        match_en  = 1'b0;
        ram_re    = 1'b0;
        commit    = 1'b0;
        case (state_reg)
            ST_IDLE:   req_stall = 1'b0;
            ST_MATCH:  match_en  = 1'b1;
            ST_SELECT: ram_re    = 1'b1;
            ST_UPDATE: commit    = slot_free;
            default:   req_stall = 1'b1;
        endcase
    end

    assign req_take = req_valid && !req_stall;
    assign ram_we   = commit && upd.we;
    assign cam_we   = commit && upd.set_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // request word and lookup result held for the whole item
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req_data;
        end
        if (ram_re)
        begin
            lk_reg <= lookup;
        end
    end

    sde_cam u_cam (
        .clk      (clk),
        .rst_n    (rst_n),
        .match_en (match_en),
        .key      (req_reg.addr_key),
        .wr_en    (cam_we),
        .wr_idx   (lk_reg.idx),
        .wr_key   (req_reg.addr_key),
        .lookup   (lookup)
    );

    // record read in select, written back in update; one item in flight
    // so the read never overlaps a pending write to the same entry
    sde_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (lk_reg.idx),
        .wdata (upd.rec),
        .re    (ram_re),
        .raddr (lookup.idx),
        .rdata (rd_rec)
    );

    sde_update u_update (
        .req    (req_reg),
        .lookup (lk_reg),
        .rec    (rd_rec),
        .cfg    (cfg_reg),
        .upd    (upd)
    );

    // result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_data_reg.pass    <= upd.pass;
            rsp_data_reg.tracked <= upd.tracked;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // ram and key store are only written at the end of an item
    a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we || cam_we) |-> (state_reg == ST_UPDATE))
        else $error("tracker write outside update step");

    // a taken request starts a lookup in the next cycle
    a_take_starts_match: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (state_reg == ST_MATCH))
        else $error("request taken without starting a lookup");

    // a new result word only follows an update step
    a_rsp_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_UPDATE))
        else $error("result word without an update step");

    // a banned verdict is always for a tracked address
    a_block_is_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !upd.pass) |-> (upd.tracked && lk_reg.hit))
        else $error("blocked verdict for an untracked address");

endmodule

[bench/tb_scan_detect_escalating_block.sv]
// self-checking bench for the address scan detector with escalating ban
`timescale 1ns / 1ps

module tb_scan_detect_escalating_block
    import sde_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid = 1'b0;
    logic                  req_stall;
    req_word_t             req_data  = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_word_t             rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    scan_detect_escalating_block DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    // request words waiting to be driven, verdicts waiting to come back
    req_word_t req_backlog[$];
    rsp_word_t verdicts_due[$];

    bit                req_taken  = 1'b0;
    bit                no_gaps    = 1'b0;
    int                mismatches = 0;
    int                cycles     = 0;
    int                items_made = 0;
    logic [TIME_W-1:0] wall_sec   = '0;
    logic [KEY_W-1:0]  addr_pool[$];

    // bench copy of the limiter settings, reset values as after rst_n
    logic [WIN_W-1:0]  lim_window     = 16'd60;
    logic [CNT_W-1:0]  lim_threshold  = 8'd10;
    logic [LEN_W-1:0]  ban_len_first  = 24'd300;
    logic [LEN_W-1:0]  ban_len_second = 24'd3600;
    logic [LEN_W-1:0]  ban_len_third  = 24'd86400;

    // bench copy of the tracker table
    logic               trk_valid  [TRACKER_ENTRIES];
    logic [KEY_W-1:0]   trk_key    [TRACKER_ENTRIES];
    logic [CNT_W-1:0]   trk_count  [TRACKER_ENTRIES];
    logic [TIME_W-1:0]  trk_start  [TRACKER_ENTRIES];
    logic [STRK_W-1:0]  trk_strikes[TRACKER_ENTRIES];
    logic               trk_banned [TRACKER_ENTRIES];
    logic [UNTIL_W-1:0] trk_until  [TRACKER_ENTRIES];

    initial
    begin
        foreach (trk_valid[i])
            trk_valid[i] = 1'b0;
    end

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // updates the tracker copy for one request word and returns its verdict
    function automatic rsp_word_t judge_request(input req_word_t w);
        rsp_word_t         v;
        int                i;
        int                hit;
        int                spare;
        logic [TIME_W-1:0] elapsed;
        logic [LEN_W-1:0]  len;
        hit   = -1;
        spare = -1;
        // walking downwards leaves the lowest matching and lowest free entry
        for (i = TRACKER_ENTRIES - 1; i >= 0; i--)
        begin
            if (trk_valid[i] && trk_key[i] == w.addr_key)
                hit = i;
            if (!trk_valid[i])
                spare = i;
        end
        v.pass    = 1'b1;
        v.tracked = 1'b0;
        if (w.req_type == REQ_CHECK)
        begin
            if (hit >= 0)
            begin
                v.tracked = 1'b1;
                if (trk_banned[hit])
                begin
                    // ban holds while its end lies strictly ahead
                    if (trk_until[hit] > {1'b0, w.now_sec})
                        v.pass = 1'b0;
                    else
                    begin
                        trk_banned[hit]  = 1'b0;
                        trk_count[hit]   = '0;
                        trk_strikes[hit] = '0;
                    end
                end
            end
        end
        else if (hit < 0)
        begin
            // full table lets an untracked address through
            if (spare >= 0)
            begin
                trk_valid[spare]   = 1'b1;
                trk_key[spare]     = w.addr_key;
                trk_count[spare]   = CNT_W'(1);
                trk_start[spare]   = w.now_sec;
                trk_strikes[spare] = '0;
                trk_banned[spare]  = 1'b0;
                v.tracked          = 1'b1;
            end
        end
        else
        begin
            v.tracked = 1'b1;
            elapsed   = w.now_sec - trk_start[hit];
            if (elapsed > lim_window)
            begin
                // window over: restart counting, any ban is left alone
                trk_count[hit] = CNT_W'(1);
                trk_start[hit] = w.now_sec;
            end
            else
            begin
                if (trk_count[hit] != CNT_MAX)
                    trk_count[hit] += 1'b1;
                if (trk_count[hit] > lim_threshold)
                begin
                    if (trk_strikes[hit] != STRIKE_MAX)
                        trk_strikes[hit] += 1'b1;
                    if (trk_strikes[hit] == STRIKE_ONE)
                        len = ban_len_first;
                    else if (trk_strikes[hit] == STRIKE_TWO)
                        len = ban_len_second;
                    else
                        len = ban_len_third;
                    trk_until[hit]  = {1'b0, w.now_sec} + len;
                    trk_banned[hit] = 1'b1;
                    trk_count[hit]  = '0;
                    v.pass          = 1'b0;
                end
            end
        end
        return v;
    endfunction

    // request driver: new word only once the previous one has been taken
    always @(negedge clk)
    begin
        if (!req_valid || req_taken)
        begin
            if (req_backlog.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 32))
            begin
                req_data  <= req_backlog.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge clk)
        rsp_stall <= !no_gaps && ($urandom_range(0, 99) < 32);

    // monitor: predict on every taken request, check every taken result
    always @(posedge clk)
    begin
        req_taken <= req_valid && !req_stall;
        if (req_valid && !req_stall)
            verdicts_due.push_back(judge_request(req_data));
        if (rsp_valid && !rsp_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: result word with none outstanding, expected nothing, got %b",
                         $time, rsp_data);
                mismatches++;
            end
            else
            begin
                rsp_word_t due;
                due = verdicts_due.pop_front();
                if (rsp_data.pass !== due.pass)
                begin
                    $display("%0t: pass mismatch, expected %0b, got %0b",
                             $time, due.pass, rsp_data.pass);
                    mismatches++;
                end
                if (rsp_data.tracked !== due.tracked)
                begin
                    $display("%0t: tracked mismatch, expected %0b, got %0b",
                             $time, due.tracked, rsp_data.tracked);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_req(input logic kind, input logic [KEY_W-1:0] key,
                             input logic [TIME_W-1:0] at);
        req_word_t w;
        w.req_type = kind;
        w.addr_key = key;
        w.now_sec  = at;
        req_backlog.push_back(w);
        items_made++;
    endtask

    // one register write; valid is left high for a following write
    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            CFG_SCAN_WINDOW: lim_window     = value[WIN_W-1:0];
            CFG_THRESHOLD:   lim_threshold  = value[CNT_W-1:0];
            CFG_FIRST_BLK:   ban_len_first  = value[LEN_W-1:0];
            CFG_SECOND_BLK:  ban_len_second = value[LEN_W-1:0];
            CFG_THIRD_BLK:   ban_len_third  = value[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // writes every register, junk in the unused upper bits, plus one unmapped index
    task automatic apply_settings(input logic [WIN_W-1:0] win, input logic [CNT_W-1:0] thr,
                                  input logic [LEN_W-1:0] len1, input logic [LEN_W-1:0] len2,
                                  input logic [LEN_W-1:0] len3);
        logic [31:0] junk;
        junk = $urandom;
        cfg_write(CFG_SCAN_WINDOW, {junk[7:0], win});
        cfg_write(CFG_THRESHOLD, {junk[23:8], thr});
        cfg_write(CFG_FIRST_BLK, len1);
        cfg_write(CFG_SECOND_BLK, len2);
        cfg_write(CFG_THIRD_BLK, len3);
        cfg_write(CFG_THIRD_BLK + CFG_ADDR_W'($urandom_range(1, 3)), junk[31:8]);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // every request answered and the pipe given time to settle
    task automatic wait_quiet;
        do @(negedge clk);
        while (req_backlog.size() != 0 || req_valid || verdicts_due.size() != 0);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // random traffic built from scan bursts, ban waits, window restarts and noise
    task automatic add_traffic(input int budget);
        int               stop_at;
        int               kind;
        int               n;
        int               step_max;
        logic [KEY_W-1:0] key;
        logic [31:0]      span;
        stop_at = items_made + budget;
        while (items_made < stop_at)
        begin
            key  = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // burst around the threshold, kept inside one window
                if (lim_threshold < 12)
                    n = lim_threshold + $urandom_range(0, 2);
                else
                    n = $urandom_range(2, 12);
                step_max = lim_window / (n + 1);
                if (step_max > 3)
                    step_max = 3;
                repeat (n)
                begin
                    wall_sec += $urandom_range(0, step_max);
                    queue_req(REQ_ATTEMPT, key, wall_sec);
                end
                if ($urandom_range(0, 1))
                    queue_req(REQ_CHECK, key, wall_sec);
            end
            else if (kind < 75)
            begin
                // move time to just past, exactly at or short of a ban end
                case ($urandom_range(0, 2))
                    0:       span = 32'(ban_len_first);
                    1:       span = 32'(ban_len_second);
                    default: span = 32'(ban_len_third);
                endcase
                if ($urandom_range(0, 1))
                    wall_sec += span + $urandom_range(0, 1);
                else
                    wall_sec += $urandom_range(0, span);
                queue_req(REQ_CHECK, key, wall_sec);
            end
            else if (kind < 85)
            begin
                // window edge: equal keeps counting, beyond restarts
                wall_sec += lim_window + $urandom_range(0, 2);
                queue_req(REQ_ATTEMPT, key, wall_sec);
            end
            else if (kind < 93)
                queue_req($urandom_range(0, 1) ? REQ_ATTEMPT : REQ_CHECK,
                          {$urandom, $urandom}, wall_sec);
            else
            begin
                // clock jumps anywhere, backwards included
                wall_sec = $urandom;
                queue_req($urandom_range(0, 1) ? REQ_ATTEMPT : REQ_CHECK, key, wall_sec);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: widest window, lowest threshold, zero and full ban lengths
        apply_settings(16'hFFFF, 8'd1, 24'd0, 24'hFFFFFF, 24'd5);
        queue_req(REQ_CHECK, '0, 32'd0);                  // unknown address
        queue_req(REQ_ATTEMPT, '1, 32'hFFFF_FFFE);        // first entry taken
        queue_req(REQ_ATTEMPT, '1, 32'hFFFF_FFFF);        // strike one, zero length
        queue_req(REQ_CHECK, '1, 32'hFFFF_FFFF);          // end equals now: lifted
        queue_req(REQ_ATTEMPT, '1, 32'd0);                // time wraps, same window
        queue_req(REQ_ATTEMPT, '1, 32'd1);                // strike one again
        queue_req(REQ_ATTEMPT, '1, 32'd2);                // counted while banned
        queue_req(REQ_ATTEMPT, '1, 32'd3);                // strike two, full length
        queue_req(REQ_CHECK, '1, 32'd4);                  // still banned
        queue_req(REQ_ATTEMPT, '1, 32'd5);
        queue_req(REQ_ATTEMPT, '1, 32'd6);                // strike three
        queue_req(REQ_ATTEMPT, '1, 32'd7);
        queue_req(REQ_ATTEMPT, '1, 32'd8);                // strikes stay at three
        queue_req(REQ_CHECK, '1, 32'd12);                 // one second short
        queue_req(REQ_CHECK, '1, 32'd13);                 // lifted, strikes cleared
        queue_req(REQ_ATTEMPT, '1, 32'd65549);            // just beyond the window
        queue_req(REQ_ATTEMPT, '1, 32'd131084);           // exactly at the window edge
        queue_req(REQ_ATTEMPT, '0, 32'd0);                // second entry
        queue_req(REQ_CHECK, '0, 32'd0);                  // tracked, not banned
        queue_req(REQ_ATTEMPT, '0, 32'hFFFF_FF00);        // window restart
        queue_req(REQ_ATTEMPT, '0, 32'hFFFF_FF01);
        queue_req(REQ_ATTEMPT, '0, 32'hFFFF_FF02);
        queue_req(REQ_ATTEMPT, '0, 32'hFFFF_FF03);        // ban end beyond 32 bits
        queue_req(REQ_CHECK, '0, 32'd5);
        queue_req(REQ_CHECK, '0, 32'hFFFF_FFFF);
        wait_quiet();

        repeat (16) addr_pool.push_back({$urandom, $urandom});
        wall_sec = $urandom;

        // reset values written back explicitly
        apply_settings(16'd60, 8'd10, 24'd300, 24'd3600, 24'd86400);
        add_traffic(120);
        wait_quiet();

        // zero window, top threshold, random long bans
        apply_settings(16'd0, 8'd254, LEN_W'($urandom), LEN_W'($urandom), LEN_W'($urandom));
        add_traffic(80);
        wait_quiet();

        // short windows and low thresholds: frequent bans and escalation
        repeat (2)
        begin
            apply_settings(WIN_W'($urandom_range(1, 200)), CNT_W'($urandom_range(1, 5)),
                           LEN_W'($urandom_range(0, 40)), LEN_W'($urandom_range(0, 200)),
                           LEN_W'($urandom_range(0, 1000)));
            add_traffic(150);
            wait_quiet();
        end

        // back-to-back stretch with maximum ban lengths
        no_gaps = 1'b1;
        apply_settings(16'hFFFF, 8'd2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        add_traffic(100);
        wait_quiet();
        no_gaps = 1'b0;

        // fill the table, then traffic against a full table
        apply_settings(WIN_W'($urandom_range(1, 1000)), CNT_W'($urandom_range(1, 8)),
                       LEN_W'($urandom_range(0, 1000)), LEN_W'($urandom_range(0, 1000)),
                       LEN_W'($urandom_range(0, 1000)));
        repeat (TRACKER_ENTRIES) queue_req(REQ_ATTEMPT, {$urandom, $urandom}, wall_sec);
        add_traffic(80);
        wait_quiet();

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
